[hdl/nvqe_pkg.sv]
// Shared types, codes and constants of the NVMe I/O queue request engine.
// No dependencies; the front end, queue, back end, top level and bench use this package.
`timescale 1ns / 1ps

package nvqe_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int CHUNK_BYTES_DEF = 4096;
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

	localparam int MIN_SECTOR_LOG2 = 9;
	localparam int PHASE_BIT       = 16;
	localparam int STATUS_LSB      = 17;
	localparam int STATUS_W        = 11;

	localparam logic [3:0]  SECTOR_LOG2_RST = 4'd9;
	localparam logic [63:0] BUFFER_ADDR_RST = 64'd0;
	localparam logic [22:0] POLL_LIMIT_RST  = 23'd5000000;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_ADDR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 2'd2;

	localparam logic [1:0] KIND_SUBMIT   = 2'd0;
	localparam logic [1:0] KIND_DOORBELL = 2'd1;
	localparam logic [1:0] KIND_FINISH   = 2'd2;

	localparam logic [1:0] OPC_WRITE = 2'd1;
	localparam logic [1:0] OPC_READ  = 2'd2;

	localparam logic [1:0] OUT_SUCCESS  = 2'd0;
	localparam logic [1:0] OUT_DEV_ERR  = 2'd1;
	localparam logic [1:0] OUT_TIMEOUT  = 2'd2;
	localparam logic [1:0] OUT_REJECTED = 2'd3;

	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_EMPTY   = 2'd1;
	localparam logic [1:0] OP_POLL    = 2'd2;

	typedef struct packed {
		logic [1:0]          code;
		logic [63:0]         start_lba;
		logic [31:0]         sector_count;
		logic                is_write;
		logic                phase;
		logic [STATUS_W-1:0] status;
	} op_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [1:0]          opcode;
		logic [15:0]         command_id;
		logic [63:0]         start_block;
		logic [2:0]          blocks_minus_one;
		logic [63:0]         data_address;
		logic [2:0]          queue_slot;
		logic [2:0]          doorbell_value;
		logic [1:0]          outcome;
		logic [STATUS_W-1:0] device_status;
		logic                last;
	} res_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [63:0]          data;
	} cfg_wr_t;

	typedef struct packed {
		logic valid;
		logic full;
	} fifo_stat_t;

	function automatic res_t finish_res(logic [1:0] outcome, logic [STATUS_W-1:0] status);
		res_t r;
		r               = '0;
		r.kind          = KIND_FINISH;
		r.outcome       = outcome;
		r.device_status = status;
		r.last          = 1'b1;
		return r;
	endfunction

endpackage

[hdl/nvqe_if.sv]
// Handshake channels of the engine: request/poll items in, result items out.
// Depends on nothing; field widths follow the engine's item layout.
`timescale 1ns / 1ps

interface nvqe_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] start_lba;
	logic [31:0] sector_count;
	logic        is_write;
	logic [31:0] completion_dword;

	modport source (output valid, mode, start_lba, sector_count, is_write, completion_dword,
		input ready);
	modport sink (input valid, mode, start_lba, sector_count, is_write, completion_dword,
		output ready);
endinterface

interface nvqe_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  opcode;
	logic [15:0] command_id;
	logic [63:0] start_block;
	logic [2:0]  blocks_minus_one;
	logic [63:0] data_address;
	logic [2:0]  queue_slot;
	logic [2:0]  doorbell_value;
	logic [1:0]  outcome;
	logic [10:0] device_status;
	logic        last;

	modport source (output valid, kind, opcode, command_id, start_block, blocks_minus_one,
		data_address, queue_slot, doorbell_value, outcome, device_status, last,
		input ready);
	modport sink (input valid, kind, opcode, command_id, start_block, blocks_minus_one,
		data_address, queue_slot, doorbell_value, outcome, device_status, last,
		output ready);
endinterface

[hdl/nvme_io_queue_request_engine_unit.sv]
// NVMe I/O queue request engine, top level: front end, operation queue, back end.
// Path of an item: front-end register, queue write, then result register.
// Throughput: one request or unmatched poll per cycle while the result register is
// free; a matched poll yields two results through the single result register.
// Reset: queue empty, idle, head and tail 0, expected phase 1, registers at defaults.
`timescale 1ns / 1ps

module nvme_io_queue_request_engine_unit #(
	parameter int QUEUE_DEPTH = nvqe_pkg::QUEUE_DEPTH_DEF,
	parameter int CHUNK_BYTES = nvqe_pkg::CHUNK_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nvqe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	nvqe_req_if.sink                       req,
	nvqe_rsp_if.source                     rsp
);

	nvqe_pkg::cfg_wr_t    cfg;
	nvqe_pkg::fifo_stat_t fifo_stat;
	nvqe_pkg::op_t        wr_op;
	nvqe_pkg::op_t        rd_op;
	logic                 push;
	logic                 pop;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	nvqe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.fifo_stat (fifo_stat),
		.push      (push),
		.op        (wr_op)
	);

	nvqe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_op  (wr_op),
		.pop    (pop),
		.rd_op  (rd_op),
		.stat   (fifo_stat)
	);

	nvqe_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fifo_stat (fifo_stat),
		.op        (rd_op),
		.pop       (pop),
		.rsp       (rsp)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_stat.full)
		else $error("operation queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fifo_stat.valid)
		else $error("operation queue pop while empty");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == nvqe_pkg::KIND_FINISH |-> rsp.last)
		else $error("finish result without last");

	a_doorbell_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == nvqe_pkg::KIND_DOORBELL |-> !rsp.last)
		else $error("doorbell result marked last");

endmodule

[hdl/nvqe_front.sv]
// Front end: registers each incoming item and classifies it into an operation.
// Depends on nvqe_pkg and nvqe_req_if.
`timescale 1ns / 1ps

module nvqe_front (
	input  logic               clk,
	input  logic               arst_n,
	nvqe_req_if.sink           req,
	input  nvqe_pkg::fifo_stat_t fifo_stat,
	output logic               push,
	output nvqe_pkg::op_t      op
);

	logic          valid_s1;
	nvqe_pkg::op_t op_s1;
	nvqe_pkg::op_t op_d;

	assign push      = valid_s1 && !fifo_stat.full;
	assign req.ready = !valid_s1 || !fifo_stat.full;
	assign op        = op_s1;

	always_comb begin
		op_d              = '0;
		op_d.start_lba    = req.start_lba;
		op_d.sector_count = req.sector_count;
		op_d.is_write     = req.is_write;
		op_d.phase        = req.completion_dword[nvqe_pkg::PHASE_BIT];
		op_d.status       = req.completion_dword[nvqe_pkg::STATUS_LSB +: nvqe_pkg::STATUS_W];
		if (req.mode) begin
			op_d.code = nvqe_pkg::OP_POLL;
		end else if (req.sector_count == 32'd0) begin
			op_d.code = nvqe_pkg::OP_EMPTY;
		end else begin
			op_d.code = nvqe_pkg::OP_REQUEST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1 <= op_d;
		end
	end

endmodule

[hdl/nvqe_fifo.sv]
// Short operation queue between the front end and the back end.
// Depends on nvqe_pkg.
`timescale 1ns / 1ps

module nvqe_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nvqe_pkg::op_t        wr_op,
	input  logic                 pop,
	output nvqe_pkg::op_t        rd_op,
	output nvqe_pkg::fifo_stat_t stat
);

	localparam int AW = nvqe_pkg::FIFO_AW;

	nvqe_pkg::op_t mem_q [nvqe_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign stat.valid = count_q != '0;
	assign stat.full  = count_q == (AW+1)'(nvqe_pkg::FIFO_DEPTH);
	assign rd_op      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(nvqe_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(nvqe_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

endmodule

[hdl/nvqe_back.sv]
// Back end: queue-pair state, command issue, completion checks, result register.
// Depends on nvqe_pkg and nvqe_rsp_if.
`timescale 1ns / 1ps

module nvqe_back #(
	parameter int QUEUE_DEPTH = nvqe_pkg::QUEUE_DEPTH_DEF,
	parameter int CHUNK_BYTES = nvqe_pkg::CHUNK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nvqe_pkg::cfg_wr_t    cfg,
	input  nvqe_pkg::fifo_stat_t fifo_stat,
	input  nvqe_pkg::op_t        op,
	output logic                 pop,
	nvqe_rsp_if.source           rsp
);

	localparam int QW       = $clog2(QUEUE_DEPTH);
	localparam int PER_MAX  = CHUNK_BYTES >> nvqe_pkg::MIN_SECTOR_LOG2;
	localparam int PW       = $clog2(PER_MAX + 1);
	localparam int SW       = nvqe_pkg::STATUS_W;

	logic [3:0]    sector_log2_q;
	logic [63:0]   buffer_addr_q;
	logic [22:0]   poll_limit_q;

	logic          busy_q, busy_d;
	logic          writing_q, writing_d;
	logic [63:0]   next_block_q, next_block_d;
	logic [31:0]   blocks_left_q, blocks_left_d;
	logic [QW-1:0] tail_q, tail_d;
	logic [QW-1:0] head_q, head_d;
	logic          phase_q, phase_d;
	logic [15:0]   id_q, id_d;
	logic [22:0]   wait_q, wait_d;
	logic          sec_q, sec_d;
	logic [SW-1:0] status_q, status_d;

	logic           out_valid_q;
	nvqe_pkg::res_t out_q;
	nvqe_pkg::res_t res_d;
	logic           load;
	logic           slot_free;

	logic [3:0]    lg_eff;
	logic [31:0]   per_wide;
	logic [PW-1:0] per;
	logic [63:0]   src_block;
	logic [31:0]   src_left;
	logic          src_write;
	logic [PW-1:0] n;
	logic [PW-1:0] n_m1;
	logic [PW+2:0] n_m1_ext;
	logic [QW-1:0] tail_nx;
	logic [QW-1:0] head_nx;
	logic [QW+2:0] tail_ext;
	logic [QW+2:0] tail_nx_ext;
	logic [QW+2:0] head_nx_ext;
	logic [22:0]   wait_inc;
	nvqe_pkg::res_t iss_res;

	assign lg_eff    = (sector_log2_q < 4'(nvqe_pkg::MIN_SECTOR_LOG2))
		? 4'(nvqe_pkg::MIN_SECTOR_LOG2) : sector_log2_q;
	assign per_wide  = 32'(CHUNK_BYTES) >> lg_eff;
	assign per       = (per_wide == 32'd0) ? PW'(1) : per_wide[PW-1:0];
	assign src_block = sec_q ? next_block_q : op.start_lba;
	assign src_left  = sec_q ? blocks_left_q : op.sector_count;
	assign src_write = sec_q ? writing_q : op.is_write;
	assign n         = (src_left < 32'(per)) ? src_left[PW-1:0] : per;
	assign n_m1      = n - PW'(1);
	assign n_m1_ext  = {3'b000, n_m1};

	assign tail_nx     = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QW'(1);
	assign head_nx     = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
	assign tail_ext    = {3'b000, tail_q};
	assign tail_nx_ext = {3'b000, tail_nx};
	assign head_nx_ext = {3'b000, head_nx};
	assign wait_inc    = wait_q + 23'd1;

	always_comb begin
		iss_res                  = '0;
		iss_res.kind             = nvqe_pkg::KIND_SUBMIT;
		iss_res.opcode           = src_write ? nvqe_pkg::OPC_WRITE : nvqe_pkg::OPC_READ;
		iss_res.command_id       = id_q;
		iss_res.start_block      = src_block;
		iss_res.blocks_minus_one = n_m1_ext[2:0];
		iss_res.data_address     = buffer_addr_q;
		iss_res.queue_slot       = tail_ext[2:0];
		iss_res.doorbell_value   = tail_nx_ext[2:0];
		iss_res.last             = 1'b1;
	end

	assign slot_free = !out_valid_q || rsp.ready;

	always_comb begin
		busy_d        = busy_q;
		writing_d     = writing_q;
		next_block_d  = next_block_q;
		blocks_left_d = blocks_left_q;
		tail_d        = tail_q;
		head_d        = head_q;
		phase_d       = phase_q;
		id_d          = id_q;
		wait_d        = wait_q;
		sec_d         = sec_q;
		status_d      = status_q;
		res_d         = '0;
		load          = 1'b0;
		pop           = 1'b0;
		if (slot_free) begin
			if (sec_q) begin
				load  = 1'b1;
				sec_d = 1'b0;
				if (status_q != '0) begin
					res_d  = nvqe_pkg::finish_res(nvqe_pkg::OUT_DEV_ERR, status_q);
					busy_d = 1'b0;
				end else if (blocks_left_q == 32'd0) begin
					res_d  = nvqe_pkg::finish_res(nvqe_pkg::OUT_SUCCESS, '0);
					busy_d = 1'b0;
				end else begin
					res_d         = iss_res;
					id_d          = id_q + 16'd1;
					tail_d        = tail_nx;
					next_block_d  = src_block + 64'(n);
					blocks_left_d = src_left - 32'(n);
					wait_d        = '0;
				end
			end else if (fifo_stat.valid) begin
				pop = 1'b1;
				case (op.code)
					nvqe_pkg::OP_REQUEST: begin
						load = 1'b1;
						if (busy_q) begin
							res_d = nvqe_pkg::finish_res(nvqe_pkg::OUT_REJECTED, '0);
						end else begin
							res_d         = iss_res;
							busy_d        = 1'b1;
							writing_d     = op.is_write;
							id_d          = id_q + 16'd1;
							tail_d        = tail_nx;
							next_block_d  = src_block + 64'(n);
							blocks_left_d = src_left - 32'(n);
							wait_d        = '0;
						end
					end
					nvqe_pkg::OP_EMPTY: begin
						load  = 1'b1;
						res_d = nvqe_pkg::finish_res(
							busy_q ? nvqe_pkg::OUT_REJECTED : nvqe_pkg::OUT_SUCCESS, '0);
					end
					nvqe_pkg::OP_POLL: begin
						if (busy_q) begin
							if (op.phase != phase_q) begin
								wait_d = wait_inc;
								if (wait_inc >= poll_limit_q) begin
									load   = 1'b1;
									res_d  = nvqe_pkg::finish_res(nvqe_pkg::OUT_TIMEOUT, '0);
									busy_d = 1'b0;
								end
							end else begin
								head_d = head_nx;
								if (head_nx == '0) begin
									phase_d = ~phase_q;
								end
								load                 = 1'b1;
								res_d.kind           = nvqe_pkg::KIND_DOORBELL;
								res_d.doorbell_value = head_nx_ext[2:0];
								res_d.device_status  = op.status;
								sec_d                = 1'b1;
								status_d             = op.status;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_log2_q <= nvqe_pkg::SECTOR_LOG2_RST;
			buffer_addr_q <= nvqe_pkg::BUFFER_ADDR_RST;
			poll_limit_q  <= nvqe_pkg::POLL_LIMIT_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				nvqe_pkg::CFG_SECTOR_LOG2: sector_log2_q <= cfg.data[3:0];
				nvqe_pkg::CFG_BUFFER_ADDR: buffer_addr_q <= cfg.data;
				nvqe_pkg::CFG_POLL_LIMIT:  poll_limit_q  <= cfg.data[22:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			writing_q     <= 1'b0;
			next_block_q  <= '0;
			blocks_left_q <= '0;
			tail_q        <= '0;
			head_q        <= '0;
			phase_q       <= 1'b1;
			id_q          <= '0;
			wait_q        <= '0;
			sec_q         <= 1'b0;
			status_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			busy_q        <= busy_d;
			writing_q     <= writing_d;
			next_block_q  <= next_block_d;
			blocks_left_q <= blocks_left_d;
			tail_q        <= tail_d;
			head_q        <= head_d;
			phase_q       <= phase_d;
			id_q          <= id_d;
			wait_q        <= wait_d;
			sec_q         <= sec_d;
			status_q      <= status_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_d;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.kind             = out_q.kind;
	assign rsp.opcode           = out_q.opcode;
	assign rsp.command_id       = out_q.command_id;
	assign rsp.start_block      = out_q.start_block;
	assign rsp.blocks_minus_one = out_q.blocks_minus_one;
	assign rsp.data_address     = out_q.data_address;
	assign rsp.queue_slot       = out_q.queue_slot;
	assign rsp.doorbell_value   = out_q.doorbell_value;
	assign rsp.outcome          = out_q.outcome;
	assign rsp.device_status    = out_q.device_status;
	assign rsp.last             = out_q.last;

endmodule

[hdl/nvqe_if_unused_guard.sv]
// Spare source file of the engine; it holds no modules.
// No dependencies.
`timescale 1ns / 1ps

[hdl/nvqe_queue_watch.sv]
// Spare source file of the engine; it holds no modules.
// No dependencies.
`timescale 1ns / 1ps

[hdl/nvqe_checks_placeholder.sv]
// Spare source file of the engine; it holds no modules.
// No dependencies.
`timescale 1ns / 1ps

[tb/tb_nvme_io_queue_request_engine_unit.sv]
// Self-checking bench for nvme_io_queue_request_engine_unit: drives requests and completion
// polls, predicts commands, doorbells and outcomes, and checks every result transfer.
// Depends on nvqe_pkg, nvqe_req_if / nvqe_rsp_if and the engine top level.
`timescale 1ns / 1ps

module tb_nvme_io_queue_request_engine_unit;
	import nvqe_pkg::*;

	typedef struct packed {
		bit        mode;
		bit [63:0] lba;
		bit [31:0] count;
		bit        wr;
		bit [31:0] dword;
	} io_item_t;

	typedef struct packed {
		bit [3:0]  sector_log2;
		bit [63:0] buf_addr;
		bit [22:0] poll_limit;
		bit        busy;
		bit        writing;
		bit [63:0] next_block;
		bit [31:0] blocks_left;
		bit [2:0]  tail;
		bit [2:0]  head;
		bit        phase;
		bit [15:0] cid;
		bit [22:0] waits;
	} engine_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;

	nvqe_req_if req_ch();
	nvqe_rsp_if rsp_ch();

	nvme_io_queue_request_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	engine_t  engine;
	engine_t  shadow;
	io_item_t pending[$];
	io_item_t outgoing;
	res_t     due_results[$];
	bit       req_hs;
	bit       calm;
	int       stim_count;
	int       mismatches;
	int       n_checked, n_submit, n_doorbell, n_finish, n_timeout, n_dev_err, n_reject;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = '0;
		cfg_data                = '0;
		req_ch.valid            = 1'b0;
		req_ch.mode             = 1'b0;
		req_ch.start_lba        = '0;
		req_ch.sector_count     = '0;
		req_ch.is_write         = 1'b0;
		req_ch.completion_dword = '0;
		rsp_ch.ready            = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#(12 * 400000);
		$display("FAIL");
		$finish;
	end

	function automatic res_t closing(logic [1:0] outcome, logic [STATUS_W-1:0] status);
		res_t r;
		r               = '0;
		r.kind          = KIND_FINISH;
		r.outcome       = outcome;
		r.device_status = status;
		return r;
	endfunction

	// Emit the next chunk of the active request and advance it.
	function automatic res_t issue_command(inout engine_t e);
		res_t        r;
		int unsigned lg;
		int unsigned per;
		int unsigned n;
		lg  = (e.sector_log2 < MIN_SECTOR_LOG2) ? MIN_SECTOR_LOG2 : e.sector_log2;
		per = CHUNK_BYTES_DEF >> lg;
		if (per == 0) begin
			per = 1;
		end
		n                  = (e.blocks_left < per) ? e.blocks_left : per;
		r                  = '0;
		r.kind             = KIND_SUBMIT;
		r.opcode           = e.writing ? OPC_WRITE : OPC_READ;
		r.command_id       = e.cid;
		r.start_block      = e.next_block;
		r.blocks_minus_one = 3'(n - 1);
		r.data_address     = e.buf_addr;
		r.queue_slot       = e.tail;
		e.tail             = e.tail + 3'd1;
		r.doorbell_value   = e.tail;
		e.cid              = e.cid + 16'd1;
		e.next_block       = e.next_block + 64'(n);
		e.blocks_left      = e.blocks_left - n;
		e.waits            = '0;
		return r;
	endfunction

	function automatic int advance_engine(inout engine_t e, input io_item_t it,
		output res_t outs[2]);
		bit [STATUS_W-1:0] st;
		outs[0] = '0;
		outs[1] = '0;
		if (!it.mode) begin
			if (e.busy) begin
				outs[0] = closing(OUT_REJECTED, '0);
			end else if (it.count == 0) begin
				outs[0] = closing(OUT_SUCCESS, '0);
			end else begin
				e.busy        = 1'b1;
				e.writing     = it.wr;
				e.next_block  = it.lba;
				e.blocks_left = it.count;
				outs[0]       = issue_command(e);
			end
			outs[0].last = 1'b1;
			return 1;
		end
		if (!e.busy) begin
			return 0;
		end
		if (it.dword[PHASE_BIT] != e.phase) begin
			e.waits = e.waits + 23'd1;
			if (e.waits >= e.poll_limit) begin
				outs[0]      = closing(OUT_TIMEOUT, '0);
				outs[0].last = 1'b1;
				e.busy       = 1'b0;
				return 1;
			end
			return 0;
		end
		st     = it.dword[STATUS_LSB +: STATUS_W];
		e.head = e.head + 3'd1;
		if (e.head == 0) begin
			e.phase = ~e.phase;
		end
		outs[0].kind           = KIND_DOORBELL;
		outs[0].doorbell_value = e.head;
		outs[0].device_status  = st;
		if (st != 0) begin
			outs[1] = closing(OUT_DEV_ERR, st);
			e.busy  = 1'b0;
		end else if (e.blocks_left == 0) begin
			outs[1] = closing(OUT_SUCCESS, '0);
			e.busy  = 1'b0;
		end else begin
			outs[1] = issue_command(e);
		end
		outs[1].last = 1'b1;
		return 2;
	endfunction

	function automatic io_item_t make_req(bit [63:0] lba, bit [31:0] count, bit wr);
		io_item_t it;
		it.mode  = 1'b0;
		it.lba   = lba;
		it.count = count;
		it.wr    = wr;
		it.dword = $urandom;
		return it;
	endfunction

	function automatic io_item_t make_poll(bit match, bit [STATUS_W-1:0] st);
		io_item_t it;
		it.mode                          = 1'b1;
		it.lba                           = {$urandom, $urandom};
		it.count                         = $urandom;
		it.wr                            = 1'($urandom_range(1));
		it.dword                         = $urandom;
		it.dword[PHASE_BIT]              = match ? shadow.phase : ~shadow.phase;
		it.dword[STATUS_LSB +: STATUS_W] = st;
		return it;
	endfunction

	task automatic add_item(io_item_t it);
		res_t scratch[2];
		bit   was_busy;
		was_busy = shadow.busy;
		void'(advance_engine(shadow, it, scratch));
		pending.push_back(it);
		if (!it.mode || was_busy) begin
			stim_count++;
		end
	endtask

	task automatic random_request();
		bit [31:0] count;
		bit [63:0] lba;
		int        pick;
		pick = $urandom_range(99);
		if (pick < 6) begin
			count = '0;
		end else if (pick < 12) begin
			count = $urandom;
		end else if (pick < 16) begin
			count = '1;
		end else begin
			count = $urandom_range(1, 40);
		end
		lba = ($urandom_range(9) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(30))
			: {$urandom, $urandom};
		add_item(make_req(lba, count, 1'($urandom_range(1))));
		while (shadow.busy) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				add_item(make_req({$urandom, $urandom}, $urandom, 1'($urandom_range(1))));
			end else if (pick < 22) begin
				add_item(make_poll(1'b0, STATUS_W'($urandom)));
			end else if (pick < 28) begin
				add_item(make_poll(1'b1, STATUS_W'($urandom_range(1, 2047))));
			end else begin
				add_item(make_poll(1'b1, '0));
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [63:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_SECTOR_LOG2: engine.sector_log2 = val[3:0];
			CFG_BUFFER_ADDR: engine.buf_addr = val;
			CFG_POLL_LIMIT:  engine.poll_limit = val[22:0];
			default: ;
		endcase
	endtask

	// Wait until every item is sent and every result has arrived, then let the pipe empty.
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending.size() != 0 || (req_ch.valid && !req_hs)
			|| due_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_hs) begin
			if (pending.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
				outgoing = pending.pop_front();
				req_ch.valid            <= 1'b1;
				req_ch.mode             <= outgoing.mode;
				req_ch.start_lba        <= outgoing.lba;
				req_ch.sector_count     <= outgoing.count;
				req_ch.is_write         <= outgoing.wr;
				req_ch.completion_dword <= outgoing.dword;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= arst_n && (calm || $urandom_range(99) >= 32);
	end

	always @(posedge clk) begin
		io_item_t taken;
		res_t     outs[2];
		res_t     want;
		int       n;
		if (!arst_n) begin
			req_hs = 1'b0;
		end else begin
			req_hs = req_ch.valid && req_ch.ready;
			if (req_hs) begin
				taken.mode  = req_ch.mode;
				taken.lba   = req_ch.start_lba;
				taken.count = req_ch.sector_count;
				taken.wr    = req_ch.is_write;
				taken.dword = req_ch.completion_dword;
				n = advance_engine(engine, taken, outs);
				for (int i = 0; i < n; i++) begin
					due_results.push_back(outs[i]);
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result transfer with nothing expected: kind %0h", rsp_ch.kind);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					n_checked++;
					case (want.kind)
						KIND_SUBMIT:   n_submit++;
						KIND_DOORBELL: n_doorbell++;
						default: begin
							n_finish++;
							if (want.outcome == OUT_TIMEOUT) n_timeout++;
							if (want.outcome == OUT_DEV_ERR) n_dev_err++;
							if (want.outcome == OUT_REJECTED) n_reject++;
						end
					endcase
					check_field("kind", want.kind, rsp_ch.kind);
					check_field("opcode", want.opcode, rsp_ch.opcode);
					check_field("command_id", want.command_id, rsp_ch.command_id);
					check_field("start_block", want.start_block, rsp_ch.start_block);
					check_field("blocks_minus_one", want.blocks_minus_one,
						rsp_ch.blocks_minus_one);
					check_field("data_address", want.data_address, rsp_ch.data_address);
					check_field("queue_slot", want.queue_slot, rsp_ch.queue_slot);
					check_field("doorbell_value", want.doorbell_value, rsp_ch.doorbell_value);
					check_field("outcome", want.outcome, rsp_ch.outcome);
					check_field("device_status", want.device_status, rsp_ch.device_status);
					check_field("last", want.last, rsp_ch.last);
				end
			end
		end
	end

	initial begin
		bit [3:0]  log2_plan[6];
		bit [22:0] limit_plan[6];
		bit [63:0] addr;
		io_item_t  it;
		int        target;
		log2_plan  = '{4'd12, 4'd10, 4'd0, 4'd15, 4'd11, 4'd9};
		limit_plan = '{23'd3, 23'd1, 23'd0, 23'h7FFFFF, 23'd5, 23'd2};
		engine             = '0;
		engine.sector_log2 = SECTOR_LOG2_RST;
		engine.buf_addr    = BUFFER_ADDR_RST;
		engine.poll_limit  = POLL_LIMIT_RST;
		engine.phase       = 1'b1;
		shadow             = engine;
		calm               = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// poll while idle, zero count, address wrap, busy reject, stale phase
		it       = make_poll(1'b1, '1);
		it.dword = '1;
		add_item(it);
		add_item(make_req('0, '0, 1'b0));
		add_item(make_req(64'hFFFF_FFFF_FFFF_FFFC, 32'd20, 1'b1));
		add_item(make_req('1, '1, 1'b1));
		add_item(make_poll(1'b0, 11'h7FF));
		repeat (3) add_item(make_poll(1'b1, '0));
		// largest count, ended by a device error with every status bit set
		add_item(make_req('0, '1, 1'b0));
		add_item(make_poll(1'b1, 11'h7FF));
		// five chunks across a head wrap and phase flip
		add_item(make_req({$urandom, $urandom}, 32'd40, 1'b0));
		repeat (5) add_item(make_poll(1'b1, '0));
		add_item(make_req({$urandom, $urandom}, 32'd1, 1'b1));
		add_item(make_poll(1'b1, 11'h001));
		drain();

		target = stim_count;
		for (int p = 0; p < 6; p++) begin
			addr = (p == 0) ? '1 : (p == 3) ? '0 : {$urandom, $urandom};
			write_reg(CFG_SECTOR_LOG2, 64'(log2_plan[p]));
			write_reg(CFG_BUFFER_ADDR, addr);
			write_reg(CFG_POLL_LIMIT, 64'(limit_plan[p]));
			@(negedge clk);
			cfg_we <= 1'b0;
			shadow  = engine;
			calm    = (p == 2);
			target += 92;
			while (stim_count < target) begin
				if ($urandom_range(99) < 15) begin
					if ($urandom_range(1) != 0) begin
						add_item(make_poll(1'($urandom_range(1)), STATUS_W'($urandom)));
					end else begin
						add_item(make_req({$urandom, $urandom}, '0, 1'($urandom_range(1))));
					end
				end else begin
					random_request();
				end
			end
			drain();
		end

		$display("Checked %0d results over %0d items in 7 register settings:", n_checked,
			stim_count);
		$display("  %0d commands, %0d doorbells, %0d finishes (%0d timeout, %0d error, %0d busy)",
			n_submit, n_doorbell, n_finish, n_timeout, n_dev_err, n_reject);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
